/* hdl/counter_timestamp_unwrap_defines.svh */
`ifndef COUNTER_TIMESTAMP_UNWRAP_DEFINES_SVH
`define COUNTER_TIMESTAMP_UNWRAP_DEFINES_SVH

// same-cycle check, disabled while reset is low
`define CTU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, disabled while reset is low
`define CTU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ctu_pkg.sv */
`timescale 1ns / 1ps

package ctu_pkg;

    localparam logic [31:0] HALF_MARK      = 32'h7FFF_FFFF;
    localparam logic [19:0] US_PER_SEC     = 20'd1000000;
    localparam logic [30:0] CLOCK_FREQ_RST = 31'd80000000;
    localparam int          QUEUE_DEPTH    = 2;
    localparam int          QUEUE_AW       = 1;
    localparam int          DIV_STEPS      = 64;

    typedef enum logic [1:0] {
        CFG_START_COUNT = 2'd0,
        CFG_BASE_TIME   = 2'd1,
        CFG_CLOCK_FREQ  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_ABS,
        B_DIV,
        B_SIGN,
        B_DONE
    } back_state_t;

    // one classified reading on its way to the back end
    typedef struct packed {
        logic        accepted;
        logic [63:0] ticks;
    } ctu_item_t;

    // reload of the tracking state on a start count write
    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } ctu_reload_t;

endpackage

/* hdl/counter_timestamp_unwrap.sv */
// channel   direction  handshake            payload
// s_        in         s_valid/s_ready      s_count[31:0]
// m_        out        m_valid/m_ready      m_accepted, m_time_us[63:0]
// cfg_      in         cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[63:0]
//
// a word is classified the cycle it is taken and, if accepted, tracked; the back
// end takes one word at a time and for an accepted one runs two 32x20 partial
// products, sum, magnitude, a 64-step restoring divide by clock_freq, sign fix
// and the base time add, a rejected one goes straight to finish; a 2-word queue
// sits between; reset clears tracking, queue and output valid; no clearing pass
// a stalled m_ready holds the result register and backs up into the queue
`timescale 1ns / 1ps

module counter_timestamp_unwrap import ctu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [63:0] m_time_us,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [31:0] start_count_reg;
    logic [63:0] base_time_reg;
    logic [30:0] clock_freq_reg;
    logic        cfg_write;
    ctu_reload_t reload;
    logic        push_valid;
    logic        push_ready;
    ctu_item_t   push_item;
    logic        pop_valid;
    logic        pop_ready;
    ctu_item_t   pop_item;

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign reload.load  = cfg_write && (cfg_index == CFG_START_COUNT);
    assign reload.value = cfg_data[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_count_reg <= '0;
            base_time_reg   <= '0;
            clock_freq_reg  <= CLOCK_FREQ_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_START_COUNT: start_count_reg <= cfg_data[31:0];
                CFG_BASE_TIME:   base_time_reg   <= cfg_data;
                CFG_CLOCK_FREQ:  clock_freq_reg  <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    ctu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .reload      (reload),
        .start_count (start_count_reg),
        .clock_freq  (clock_freq_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_count     (s_count),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    ctu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ctu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .base_time  (base_time_reg),
        .clock_freq (clock_freq_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_accepted (m_accepted),
        .m_time_us  (m_time_us)
    );

endmodule

/* hdl/ctu_front.sv */
`timescale 1ns / 1ps

module ctu_front import ctu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  ctu_reload_t reload,
    input  logic [31:0] start_count,
    input  logic [30:0] clock_freq,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_count,
    output logic        push_valid,
    input  logic        push_ready,
    output ctu_item_t   push_item
);

    logic [31:0] last_count_reg, last_count_next;
    logic        upper_half_reg, upper_half_next;
    logic [31:0] rollover_reg, rollover_next;
    logic [31:0] jump;
    logic        pass;
    logic        wrap;

    assign jump = s_count - last_count_reg;
    assign pass = (jump <= {1'b0, clock_freq});
    assign wrap = (s_count < HALF_MARK) && upper_half_reg;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        rollover_next   = wrap ? rollover_reg + 32'd1 : rollover_reg;
        upper_half_next = upper_half_reg;
        if (wrap) begin
            upper_half_next = 1'b0;
        end
        if (s_count > HALF_MARK) begin
            upper_half_next = 1'b1;
        end
        last_count_next = s_count;
    end

    always_comb begin
        push_item.accepted = pass;
        push_item.ticks    = {rollover_next, s_count} - {32'd0, start_count};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg <= '0;
            upper_half_reg <= 1'b0;
            rollover_reg   <= '0;
        end else if (reload.load) begin
            last_count_reg <= reload.value;
            upper_half_reg <= reload.value > HALF_MARK;
            rollover_reg   <= '0;
        end else if (s_valid && s_ready && pass) begin
            last_count_reg <= last_count_next;
            upper_half_reg <= upper_half_next;
            rollover_reg   <= rollover_next;
        end
    end

endmodule

/* hdl/ctu_queue.sv */
`timescale 1ns / 1ps

module ctu_queue import ctu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  ctu_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output ctu_item_t pop_item
);

    ctu_item_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     fill_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (fill_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

/* hdl/ctu_back.sv */
`timescale 1ns / 1ps
`include "counter_timestamp_unwrap_defines.svh"

module ctu_back import ctu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] base_time,
    input  logic [30:0] clock_freq,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  ctu_item_t   pop_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [63:0] m_time_us
);

    back_state_t state_reg, state_next;
    logic [63:0] work_reg;
    logic [51:0] prod_lo_reg;
    logic [31:0] prod_hi_reg;
    logic [30:0] rem_reg;
    logic [5:0]  step_reg;
    logic        acc_reg;
    logic        neg_reg;
    logic        m_valid_reg;
    logic        m_accepted_reg;
    logic [63:0] m_time_us_reg;
    logic [51:0] mult_lo;
    logic [51:0] mult_hi;
    logic [31:0] rem_shift;
    logic        q_bit;
    logic        out_free;
    logic [63:0] result;

    assign mult_lo   = work_reg[31:0] * US_PER_SEC;
    assign mult_hi   = work_reg[63:32] * US_PER_SEC;
    assign rem_shift = {rem_reg, work_reg[63]};
    assign q_bit     = (rem_shift >= {1'b0, clock_freq});
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_accepted = m_accepted_reg;
    assign m_time_us  = m_time_us_reg;

    always_comb begin
        if (!acc_reg) begin
            result = '0;
        end else if (clock_freq == '0) begin
            result = base_time;
        end else begin
            result = work_reg + base_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    state_next = pop_item.accepted ? B_MUL_LO : B_DONE;
                end
            end
            B_MUL_LO: state_next = B_MUL_HI;
            B_MUL_HI: state_next = B_SUM;
            B_SUM:    state_next = B_ABS;
            B_ABS:    state_next = B_DIV;
            B_DIV: begin
                if (step_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = B_SIGN;
                end
            end
            B_SIGN:   state_next = B_DONE;
            B_DONE: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // datapath: two partial products, magnitude, restoring divide, sign
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    work_reg <= pop_item.ticks;
                    acc_reg  <= pop_item.accepted;
                end
            end
            B_MUL_LO: prod_lo_reg <= mult_lo;
            B_MUL_HI: prod_hi_reg <= mult_hi[31:0];
            B_SUM:    work_reg <= {12'd0, prod_lo_reg} + {prod_hi_reg, 32'd0};
            B_ABS: begin
                neg_reg  <= work_reg[63];
                work_reg <= work_reg[63] ? 64'd0 - work_reg : work_reg;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            B_DIV: begin
                rem_reg  <= q_bit ? 31'(rem_shift - {1'b0, clock_freq}) : rem_shift[30:0];
                work_reg <= {work_reg[62:0], q_bit};
                step_reg <= step_reg + 6'd1;
            end
            B_SIGN:   work_reg <= neg_reg ? 64'd0 - work_reg : work_reg;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_DONE && out_free) begin
            m_accepted_reg <= acc_reg;
            m_time_us_reg  <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == B_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    `CTU_ASSERT_NOW(a_reject_zero, aclk, aresetn, m_valid_reg && !m_accepted_reg, m_time_us_reg == 64'd0, "rejected word carries nonzero time")
    `CTU_ASSERT_NEXT(a_div_runs, aclk, aresetn, state_reg == B_DIV && step_reg != 6'(DIV_STEPS - 1), state_reg == B_DIV, "divide left early")
    `CTU_ASSERT_NOW(a_out_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == B_DONE), "result word raised outside finish state")

endmodule
